// ----- sv/pol_pkg.sv -----
package pol_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    // Wide enough for a position, a count and a count plus one.
    localparam int CMP_W      = ((CNT_W > 6) ? CNT_W : 6) + 1;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     hit;
    } t_cell_ctrl;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_word;
        logic [1:0]         status;
        logic [5:0]         count_after;
    } t_out_item;

endpackage

// ----- sv/pol_cell.sv -----
module pol_cell (
    input  logic                      i_clk,
    input  pol_pkg::t_cell_ctrl       i_ctrl,
    input  logic signed [31:0]        i_value,
    input  logic signed [31:0]        i_left,
    input  logic signed [31:0]        i_right,
    output logic signed [31:0]        o_word,
    output logic signed [31:0]        o_read
);

    logic signed [31:0] r_word;
    logic signed [31:0] n_word;

    always_comb begin
        case (i_ctrl.op)
            pol_pkg::CELL_LOAD:  n_word = i_value;
            pol_pkg::CELL_LEFT:  n_word = i_left;
            pol_pkg::CELL_RIGHT: n_word = i_right;
            default:             n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_read = i_ctrl.hit ? r_word : 32'sd0;

endmodule

// ----- sv/positional_ordered_list.sv -----
// The result of an accepted operation is registered and presented in the cycle after its transfer.
// Throughput: one operation per cycle; the cells at and beyond the position shift in the same cycle.
// A result held under output stall holds off the next input transfer.
// Reset clears the count and the output valid; list words are not cleared and are
// only ever read after they have been written.
module positional_ordered_list (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pol_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pol_pkg::t_out_item o_out_data
);

    localparam int DEPTH = pol_pkg::LIST_DEPTH;

    logic [pol_pkg::CNT_W-1:0] r_count;
    logic [pol_pkg::CNT_W-1:0] n_count;
    logic                      r_out_valid;
    pol_pkg::t_out_item        r_out;
    pol_pkg::t_out_item        n_out;

    logic                      accept;
    logic [pol_pkg::CMP_W-1:0] pos_c;
    logic [pol_pkg::CMP_W-1:0] cnt_c;
    logic                      pos_rd_ok;
    logic                      pos_ins_ok;
    logic                      full;
    logic                      do_insert;
    logic                      do_delete;
    logic signed [31:0]        read_sel;

    pol_pkg::t_cell_ctrl       ctrl  [DEPTH];
    logic signed [31:0]        words [DEPTH];
    logic signed [31:0]        reads [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign pos_c      = pol_pkg::CMP_W'(i_in_data.position);
    assign cnt_c      = pol_pkg::CMP_W'(r_count);
    assign pos_rd_ok  = (i_in_data.position != 6'd0) && (pos_c <= cnt_c);
    assign pos_ins_ok = (i_in_data.position != 6'd0) && (pos_c <= cnt_c + 1'b1);
    assign full       = (r_count == pol_pkg::CNT_W'(DEPTH));

    assign do_insert  = accept && (i_in_data.opcode == pol_pkg::OP_INSERT)
                        && pos_ins_ok && !full;
    assign do_delete  = accept && (i_in_data.opcode == pol_pkg::OP_DELETE) && pos_rd_ok;

    // Cell i holds list position i + 1.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            logic [pol_pkg::CMP_W-1:0] cell_pos;
            cell_pos     = pol_pkg::CMP_W'(i + 1);
            ctrl[i].hit  = (cell_pos == pos_c);
            ctrl[i].op   = pol_pkg::CELL_HOLD;
            if (do_insert) begin
                if (cell_pos == pos_c) begin
                    ctrl[i].op = pol_pkg::CELL_LOAD;
                end else if (cell_pos > pos_c) begin
                    ctrl[i].op = pol_pkg::CELL_LEFT;
                end
            end else if (do_delete && (cell_pos >= pos_c)) begin
                ctrl[i].op = pol_pkg::CELL_RIGHT;
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        pol_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl[g]),
            .i_value (i_in_data.value),
            .i_left  ((g == 0) ? 32'sd0 : words[(g == 0) ? 0 : g - 1]),
            .i_right ((g == DEPTH - 1) ? 32'sd0 : words[(g == DEPTH - 1) ? g : g + 1]),
            .o_word  (words[g]),
            .o_read  (reads[g])
        );
    end

    always_comb begin
        read_sel = 32'sd0;
        for (int i = 0; i < DEPTH; i++) begin
            read_sel = read_sel | reads[i];
        end
    end

    always_comb begin
        n_count          = r_count;
        n_out.read_word  = 32'sd0;
        n_out.status     = pol_pkg::ST_OK;
        case (i_in_data.opcode)
            pol_pkg::OP_READ: begin
                if (pos_rd_ok) begin
                    n_out.read_word = read_sel;
                end else begin
                    n_out.status = pol_pkg::ST_BADPOS;
                end
            end
            pol_pkg::OP_INSERT: begin
                if (!pos_ins_ok) begin
                    n_out.status = pol_pkg::ST_BADPOS;
                end else if (full) begin
                    n_out.status = pol_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            pol_pkg::OP_DELETE: begin
                if (pos_rd_ok) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_out.status = pol_pkg::ST_BADPOS;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.count_after = 6'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- tb/positional_ordered_list_tb.sv -----
module positional_ordered_list_tb;

    localparam logic [1:0] OP_NONE     = 2'd3;
    localparam int         N_RANDOM    = 1200;
    localparam int         HOLD_CYCLES = 200;
    localparam int         CYCLE_LIMIT = 400000;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    pol_pkg::t_in_item  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    pol_pkg::t_out_item o_out_data;

    positional_ordered_list uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // Operations waiting to be offered, and results predicted for accepted ones.
    pol_pkg::t_in_item  op_queue[$];
    pol_pkg::t_out_item predicted_results[$];

    // Shadow of the list as the hardware should hold it.
    logic signed [31:0] list_q [pol_pkg::LIST_DEPTH];
    int list_len    = 0;
    int max_len     = 0;
    int pos_errors  = 0;
    int full_reject = 0;

    int mismatches  = 0;
    int ops_taken   = 0;
    int results_ok  = 0;
    int n_directed  = 0;
    int gen_count   = 0;
    int cycles      = 0;

    logic calm      = 1'b0;
    int   calm_left = 0;
    int   tx_gap    = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    int   holds_done = 0;

    function automatic pol_pkg::t_out_item apply_list_op(input pol_pkg::t_in_item op_in);
        pol_pkg::t_out_item res;
        int p;
        res = '0;
        p = int'(op_in.position);
        case (op_in.opcode)
            pol_pkg::OP_READ: begin
                if (p < 1 || p > list_len) begin
                    res.status = pol_pkg::ST_BADPOS;
                end else begin
                    res.read_word = list_q[p-1];
                end
            end
            pol_pkg::OP_INSERT: begin
                if (p < 1 || p > list_len + 1) begin
                    res.status = pol_pkg::ST_BADPOS;
                end else if (list_len >= pol_pkg::LIST_DEPTH) begin
                    res.status = pol_pkg::ST_FULL;
                end else begin
                    for (int j = list_len; j > p - 1; j--) list_q[j] = list_q[j-1];
                    list_q[p-1] = op_in.value;
                    list_len++;
                end
            end
            pol_pkg::OP_DELETE: begin
                if (p < 1 || p > list_len) begin
                    res.status = pol_pkg::ST_BADPOS;
                end else begin
                    for (int j = p; j < list_len; j++) list_q[j-1] = list_q[j];
                    list_len--;
                end
            end
            default: ;
        endcase
        if (res.status == pol_pkg::ST_BADPOS) pos_errors++;
        if (res.status == pol_pkg::ST_FULL) full_reject++;
        if (list_len > max_len) max_len = list_len;
        res.count_after = list_len[5:0];
        return res;
    endfunction

    // The generator tracks the list length so that positions can be aimed at
    // the legal range; the length does not depend on the stored words.
    task automatic queue_op(input logic [1:0] op, input int pos, input logic [31:0] val);
        pol_pkg::t_in_item it;
        it.opcode   = op;
        it.position = pos[5:0];
        it.value    = val;
        op_queue.push_back(it);
        if (op == pol_pkg::OP_INSERT && pos >= 1 && pos <= gen_count + 1
            && gen_count < pol_pkg::LIST_DEPTH)
            gen_count++;
        else if (op == pol_pkg::OP_DELETE && pos >= 1 && pos <= gen_count)
            gen_count--;
    endtask

    function automatic int pick_gap(input logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        else if (r < 92) return $urandom_range(1, 3);
        else return $urandom_range(4, 30);
    endfunction

    task automatic report_field(input string fname, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // Alternating windows where neither side idles.
    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            calm      <= ~calm;
            calm_left <= calm ? $urandom_range(100, 400) : $urandom_range(20, 80);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap     <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (tx_gap > 0) begin
                i_in_valid <= 1'b0;
                tx_gap     <= tx_gap - 1;
            end else if (op_queue.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= op_queue.pop_front();
                tx_gap     <= pick_gap(calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Two long hold-offs let the block fill up and push back on its input.
    always @(posedge i_clk) begin : receiver
        int n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
            hold_left   <= 0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (holds_done < 2 && ops_taken >= (holds_done + 1) * 400) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            holds_done  <= holds_done + 1;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            n = pick_gap(calm);
            i_out_stall <= (n > 0);
            stall_left  <= (n > 0) ? n - 1 : 0;
        end
    end

    always @(posedge i_clk) begin : monitor
        pol_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predicted_results.push_back(apply_list_op(i_in_data));
                ops_taken <= ops_taken + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: result with nothing expected: actual %p", $time, o_out_data);
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    report_field("read_word", want.read_word, o_out_data.read_word);
                    report_field("status", 32'(want.status), 32'(o_out_data.status));
                    report_field("count_after", 32'(want.count_after),
                                 32'(o_out_data.count_after));
                    results_ok++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d operations queued and %0d results outstanding",
                     $time, op_queue.size(), predicted_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int mode;
        int mode_left;
        int r;
        int lim;
        int pos;
        logic [1:0] op;
        logic [31:0] val;

        // Directed: empty-list errors, position zero, front/middle/end inserts,
        // reads past the end, the unused opcode, and deletes at every place.
        queue_op(pol_pkg::OP_READ,   1,  32'h0);
        queue_op(pol_pkg::OP_DELETE, 1,  32'h0);
        queue_op(pol_pkg::OP_INSERT, 0,  32'h1234_5678);
        queue_op(pol_pkg::OP_INSERT, 2,  32'h1);
        queue_op(pol_pkg::OP_INSERT, 1,  32'h7FFF_FFFF);
        queue_op(pol_pkg::OP_INSERT, 1,  32'h8000_0000);
        queue_op(pol_pkg::OP_INSERT, 3,  32'hFFFF_FFFF);
        queue_op(pol_pkg::OP_INSERT, 2,  32'h0);
        for (int k = 1; k <= 5; k++) queue_op(pol_pkg::OP_READ, k, 32'hFFFF_FFFF);
        queue_op(pol_pkg::OP_READ,   0,  32'h0);
        queue_op(OP_NONE,            63, 32'h5A5A_5A5A);
        queue_op(pol_pkg::OP_DELETE, 0,  32'h0);
        queue_op(pol_pkg::OP_DELETE, 5,  32'h0);
        queue_op(pol_pkg::OP_INSERT, 63, 32'hA5A5_A5A5);
        queue_op(pol_pkg::OP_DELETE, 2,  32'h0);
        queue_op(pol_pkg::OP_DELETE, 3,  32'h0);
        queue_op(pol_pkg::OP_READ,   2,  32'h0);
        queue_op(pol_pkg::OP_DELETE, 1,  32'h0);
        queue_op(pol_pkg::OP_DELETE, 1,  32'h0);
        queue_op(pol_pkg::OP_READ,   1,  32'h0);
        n_directed = op_queue.size();

        // Random: phases that mostly fill, mostly drain, or mix, with positions
        // aimed mostly at the legal range and partly at its edges and beyond.
        mode = 0;
        mode_left = 0;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(30, 120);
            end
            mode_left--;
            r = $urandom_range(0, 99);
            case (mode)
                0:       op = (r < 70) ? pol_pkg::OP_INSERT : (r < 88) ? pol_pkg::OP_READ :
                              (r < 97) ? pol_pkg::OP_DELETE : OP_NONE;
                1:       op = (r < 65) ? pol_pkg::OP_DELETE : (r < 85) ? pol_pkg::OP_READ :
                              (r < 97) ? pol_pkg::OP_INSERT : OP_NONE;
                default: op = (r < 35) ? pol_pkg::OP_INSERT : (r < 65) ? pol_pkg::OP_READ :
                              (r < 95) ? pol_pkg::OP_DELETE : OP_NONE;
            endcase
            lim = (op == pol_pkg::OP_INSERT) ? gen_count + 1 : gen_count;
            r = $urandom_range(0, 99);
            if (r < 80 && lim >= 1) begin
                if (r < 10) pos = 1;
                else if (r < 20) pos = lim;
                else pos = $urandom_range(1, lim);
            end else if (r < 87) begin
                pos = 0;
            end else if (r < 94) begin
                pos = (lim + 1 > 63) ? 63 : lim + 1;
            end else begin
                pos = $urandom_range(0, 63);
            end
            r = $urandom_range(0, 99);
            case (r)
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'h0;
                3:       val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            queue_op(op, pos, val);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (op_queue.size() != 0 || i_in_valid || predicted_results.size() != 0);
        repeat (4) @(posedge i_clk);

        $display("Ran %0d list operations (%0d directed) and checked %0d results.",
                 ops_taken, n_directed, results_ok);
        $display("Saw %0d position errors, %0d inserts into a full list, longest list %0d.",
                 pos_errors, full_reject, max_len);
        if (mismatches == 0 && predicted_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
